@@ hdl/c2p_pkg.sv @@
// c2p_pkg: shared widths, constants, the CORDIC datapath type and the arctangent table
// for the cartesian-to-polar converter. No dependencies.
`default_nettype none
package c2p_pkg;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_ITERATIONS   = 16;

	localparam int XW      = 64;
	localparam int ZW      = 32;
	localparam int MAG_W   = 16;
	localparam int ANGLE_W = 16;
	localparam int FIX_W   = 60;
	localparam int ZFRAC   = 15;

	localparam logic signed [ZW-1:0] HALF_TURN    = 32'sd1073741824;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sd536870912;
	localparam logic [ANGLE_W-1:0]   ANGLE_MAX    = 16'd32768;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	// atan(2^-i) in units of pi/2^30
	function automatic logic signed [ZW-1:0] atan_units(input int idx);
		logic signed [ZW-1:0] t;
		case (idx)
			0:  t = 32'sd268435456;
			1:  t = 32'sd158466703;
			2:  t = 32'sd83729454;
			3:  t = 32'sd42502378;
			4:  t = 32'sd21333666;
			5:  t = 32'sd10677233;
			6:  t = 32'sd5339919;
			7:  t = 32'sd2670123;
			8:  t = 32'sd1335082;
			9:  t = 32'sd667543;
			10: t = 32'sd333772;
			11: t = 32'sd166886;
			12: t = 32'sd83443;
			13: t = 32'sd41722;
			14: t = 32'sd20861;
			15: t = 32'sd10430;
			16: t = 32'sd5215;
			17: t = 32'sd2608;
			18: t = 32'sd1304;
			19: t = 32'sd652;
			20: t = 32'sd326;
			21: t = 32'sd163;
			22: t = 32'sd81;
			23: t = 32'sd41;
			24: t = 32'sd20;
			25: t = 32'sd10;
			26: t = 32'sd5;
			27: t = 32'sd3;
			28: t = 32'sd1;
			29: t = 32'sd1;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

@@ hdl/cartesian_to_polar.sv @@
// cartesian_to_polar: top level of the pipelined cartesian-to-polar converter.
// Depends on c2p_pkg, c2p_front, c2p_iter_stage and c2p_out.
//
// Usage:
//   Input channel: real_part/imag_part with in_valid; a request is taken at a rising
//   edge with in_valid high and in_stall low. Output channel: magnitude/angle with
//   out_valid; a request leaves at an edge with out_valid high and out_stall low.
//   magnitude is the rounded modulus, angle the unsigned argument in 0..pi with
//   32768 standing for pi. A zero sample gives zero for both.
//   Pipeline: three front stages, one stage per root digit and per CORDIC iteration
//   running side by side, a rounding stage and the output register.
//   Throughput: one request per cycle while the receiver does not stall.
//   Stall: when the output is held, the next finished request drops into a one-entry
//   skid buffer and the pipeline freezes; in_stall is high exactly while that buffer
//   is full. Nothing is lost or repeated.
//   Reset: arst_n clears every valid bit at once; the block takes requests on the
//   first edge after release.
`default_nettype none
module cartesian_to_polar
	import c2p_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int ITERATIONS   = DEF_ITERATIONS
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire signed [SAMPLE_WIDTH-1:0] real_part,
	input  wire signed [SAMPLE_WIDTH-1:0] imag_part,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [MAG_W-1:0]              magnitude,
	output logic [ANGLE_W-1:0]            angle
);

	localparam int SQW   = 2 * SAMPLE_WIDTH;
	localparam int DEPTH = (SAMPLE_WIDTH > ITERATIONS) ? SAMPLE_WIDTH : ITERATIONS;

	logic            pipe_en;
	logic            v_a    [0:DEPTH];
	logic [SQW-1:0]  rem_a  [0:DEPTH];
	logic [SQW-1:0]  root_a [0:DEPTH];
	cordic_t         cord_a [0:DEPTH];

	assign in_stall  = !pipe_en;
	assign root_a[0] = '0;

	c2p_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (pipe_en),
		.in_v   (in_valid),
		.re     (real_part),
		.im     (imag_part),
		.v_s3   (v_a[0]),
		.sum_s3 (rem_a[0]),
		.cord_s3(cord_a[0])
	);

	generate
		for (genvar k = 0; k < DEPTH; k++) begin : g_stage
			c2p_iter_stage #(
				.SAMPLE_WIDTH(SAMPLE_WIDTH),
				.ITERATIONS  (ITERATIONS),
				.IDX         (k)
			) u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (pipe_en),
				.v_in   (v_a[k]),
				.rem_in (rem_a[k]),
				.root_in(root_a[k]),
				.c_in   (cord_a[k]),
				.v_s1   (v_a[k+1]),
				.rem_s1 (rem_a[k+1]),
				.root_s1(root_a[k+1]),
				.c_s1   (cord_a[k+1])
			);
		end
	endgenerate

	c2p_out #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_in     (v_a[DEPTH]),
		.rem_in   (rem_a[DEPTH]),
		.root_in  (root_a[DEPTH]),
		.c_in     (cord_a[DEPTH]),
		.out_stall(out_stall),
		.pipe_en  (pipe_en),
		.out_valid(out_valid),
		.magnitude(magnitude),
		.angle    (angle)
	);

endmodule
`default_nettype wire

@@ hdl/c2p_front.sv @@
// c2p_front: first three pipeline stages: absolute values, squares and sum for the
// root, and the CORDIC start vector. Depends on c2p_pkg.
`default_nettype none
module c2p_front
	import c2p_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           en,
	input  wire                           in_v,
	input  wire signed [SAMPLE_WIDTH-1:0] re,
	input  wire signed [SAMPLE_WIDTH-1:0] im,
	output logic                          v_s3,
	output logic [2*SAMPLE_WIDTH-1:0]     sum_s3,
	output cordic_t                       cord_s3
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int GUARD = FIX_W - SAMPLE_WIDTH;

	logic              v_s1, v_s2;
	logic [SW-1:0]     are_s1, aim_s1;
	logic              neg_s1;
	logic [2*SW-1:0]   sqre_s2, sqim_s2;
	cordic_t           cord_s2;
	logic [XW-1:0]     are_x, aim_x;
	cordic_t           cord_init;

	always_comb begin
		are_x = XW'(are_s1) << GUARD;
		aim_x = XW'(aim_s1) << GUARD;
		if (!neg_s1) begin
			cord_init.x = $signed(are_x);
			cord_init.y = $signed(aim_x);
			cord_init.z = '0;
		end else begin
			// pre-rotate by -pi/2
			cord_init.x = $signed(aim_x);
			cord_init.y = $signed(are_x);
			cord_init.z = QUARTER_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			are_s1  <= re[SW-1] ? (~re + 1'b1) : re;
			aim_s1  <= im[SW-1] ? (~im + 1'b1) : im;
			neg_s1  <= re[SW-1];
			sqre_s2 <= (2*SW)'(are_s1) * (2*SW)'(are_s1);
			sqim_s2 <= (2*SW)'(aim_s1) * (2*SW)'(aim_s1);
			cord_s2 <= cord_init;
			sum_s3  <= sqre_s2 + sqim_s2;
			cord_s3 <= cord_s2;
		end
	end

endmodule
`default_nettype wire

@@ hdl/c2p_iter_stage.sv @@
// c2p_iter_stage: one pipeline stage holding one square-root digit step and one
// CORDIC vectoring iteration. Depends on c2p_pkg.
`default_nettype none
module c2p_iter_stage
	import c2p_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int ITERATIONS   = DEF_ITERATIONS,
	parameter int IDX          = 0
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         en,
	input  wire                         v_in,
	input  wire  [2*SAMPLE_WIDTH-1:0]   rem_in,
	input  wire  [2*SAMPLE_WIDTH-1:0]   root_in,
	input  wire cordic_t                c_in,
	output logic                        v_s1,
	output logic [2*SAMPLE_WIDTH-1:0]   rem_s1,
	output logic [2*SAMPLE_WIDTH-1:0]   root_s1,
	output cordic_t                     c_s1
);

	localparam int SQW = 2 * SAMPLE_WIDTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	generate
		if (IDX < SAMPLE_WIDTH) begin : g_sqrt
			localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * IDX);
			logic [SQW-1:0] trial;
			assign trial = root_in + BIT;
			always_ff @(posedge clk) begin
				if (en) begin
					if (rem_in >= trial) begin
						rem_s1  <= rem_in - trial;
						root_s1 <= (root_in >> 1) + BIT;
					end else begin
						rem_s1  <= rem_in;
						root_s1 <= root_in >> 1;
					end
				end
			end
		end else begin : g_sqrt_hold
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s1  <= rem_in;
					root_s1 <= root_in;
				end
			end
		end

		if (IDX < ITERATIONS) begin : g_cordic
			localparam logic signed [ZW-1:0] T = atan_units(IDX);
			logic signed [XW-1:0] dx, dy;
			logic                 y_pos;
			assign dx    = c_in.y >>> IDX;
			assign dy    = c_in.x >>> IDX;
			assign y_pos = !c_in.y[XW-1] && (c_in.y != '0);
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_pos) begin
						c_s1.x <= c_in.x + dx;
						c_s1.y <= c_in.y - dy;
						c_s1.z <= c_in.z + T;
					end else begin
						c_s1.x <= c_in.x - dx;
						c_s1.y <= c_in.y + dy;
						c_s1.z <= c_in.z - T;
					end
				end
			end
		end else begin : g_cordic_hold
			always_ff @(posedge clk) begin
				if (en) begin
					c_s1 <= c_in;
				end
			end
		end
	endgenerate

endmodule
`default_nettype wire

@@ hdl/c2p_out.sv @@
// c2p_out: final rounding, clamp and saturation stage, followed by the output
// register and a one-entry skid buffer that frees the pipeline. Depends on c2p_pkg.
`default_nettype none
module c2p_out
	import c2p_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        v_in,
	input  wire  [2*SAMPLE_WIDTH-1:0]  rem_in,
	input  wire  [2*SAMPLE_WIDTH-1:0]  root_in,
	input  wire cordic_t               c_in,
	input  wire                        out_stall,
	output logic                       pipe_en,
	output logic                       out_valid,
	output logic [MAG_W-1:0]           magnitude,
	output logic [ANGLE_W-1:0]         angle
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int MW = (SAMPLE_WIDTH + 1 > MAG_W + 1) ? SAMPLE_WIDTH + 1 : MAG_W + 1;

	logic [MW-1:0]      mag_full;
	logic [ZW-2:0]      z_clamp;
	logic [ZW-2:0]      z_round;
	logic [MAG_W-1:0]   mag_d;
	logic [ANGLE_W-1:0] ang_d;

	logic               v_s1;
	logic [MAG_W-1:0]   mag_s1;
	logic [ANGLE_W-1:0] ang_s1;

	logic               out_v_q, skid_v_q;
	logic [MAG_W-1:0]   out_mag_q, skid_mag_q;
	logic [ANGLE_W-1:0] out_ang_q, skid_ang_q;
	logic               out_take;

	always_comb begin
		mag_full = MW'(root_in[SW-1:0]) + MW'(rem_in > root_in);
		mag_d    = (mag_full > MW'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : mag_full[MAG_W-1:0];
		if (c_in.z[ZW-1]) begin
			z_clamp = '0;
		end else if (c_in.z > HALF_TURN) begin
			z_clamp = HALF_TURN[ZW-2:0];
		end else begin
			z_clamp = c_in.z[ZW-2:0];
		end
		z_round = z_clamp + ((ZW-1)'(1) << (ZFRAC - 1));
		ang_d   = z_round[ZFRAC+ANGLE_W-1:ZFRAC];
	end

	assign pipe_en  = !skid_v_q;
	assign out_take = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			mag_s1 <= mag_d;
			ang_s1 <= ang_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s1;
			end
		end else if (!skid_v_q && v_s1) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			out_mag_q <= skid_v_q ? skid_mag_q : mag_s1;
			out_ang_q <= skid_v_q ? skid_ang_q : ang_s1;
		end
		if (!out_take && !skid_v_q) begin
			skid_mag_q <= mag_s1;
			skid_ang_q <= ang_s1;
		end
	end

	assign out_valid = out_v_q;
	assign magnitude = out_mag_q;
	assign angle     = out_ang_q;

endmodule
`default_nettype wire

@@ hdl/c2p_checker.sv @@
// c2p_checker: port-level assertions for cartesian_to_polar and the bind that
// attaches them. Depends on c2p_pkg and cartesian_to_polar.
`default_nettype none
module c2p_checker
	import c2p_pkg::*;
(
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_stall,
	input wire                 out_valid,
	input wire                 out_stall,
	input wire [MAG_W-1:0]     magnitude,
	input wire [ANGLE_W-1:0]   angle
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(magnitude) && $stable(angle))
		else $error("stalled output request changed");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle <= ANGLE_MAX)
		else $error("angle above pi");

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && magnitude == '0 |-> angle == '0)
		else $error("zero sample with nonzero angle");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without a held output");

	a_stall_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output empty");

endmodule

bind cartesian_to_polar c2p_checker u_c2p_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.magnitude(magnitude),
	.angle    (angle)
);
`default_nettype wire

@@ dv/tb_cartesian_to_polar.sv @@
// tb_cartesian_to_polar: self-checking testbench for the cartesian-to-polar converter,
// with its own predictor of the rounded modulus and the CORDIC argument.
// Depends on c2p_pkg and cartesian_to_polar.
module tb_cartesian_to_polar;
	import c2p_pkg::*;

	localparam int SW         = DEF_SAMPLE_WIDTH;
	localparam int ITER       = DEF_ITERATIONS;
	localparam int GUARD      = FIX_W - SW;
	localparam int LATENCY    = ((SW > ITER) ? SW : ITER) + 4;
	localparam int HOLD_LEN   = 400;
	localparam int MAX_CYCLES = 200000;

	typedef struct packed {
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
	} sample_t;

	typedef struct packed {
		logic [MAG_W-1:0]   mag;
		logic [ANGLE_W-1:0] ang;
	} polar_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic signed [SW-1:0] real_part = '0;
	logic signed [SW-1:0] imag_part = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [MAG_W-1:0]     magnitude;
	logic [ANGLE_W-1:0]   angle;

	// atan(2^-i) in units of pi/2^30
	longint atan_tbl [0:31] = '{
		268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
		5339919, 2670123, 1335082, 667543, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5,
		3, 1, 1, 0, 0
	};

	sample_t pend_q [$];
	polar_t  polar_q [$];

	int  send_idle_pct = 0;
	int  stall_pct     = 0;
	bit  hold_req      = 1'b0;
	bit  hold_seen     = 1'b0;
	int  hold_left     = 0;
	bit  in_taken      = 1'b0;
	int  n_in          = 0;
	int  n_out         = 0;
	int  n_err         = 0;
	int  n_full        = 0;
	int  n_directed    = 0;
	int  cycles        = 0;

	cartesian_to_polar DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.real_part (real_part),
		.imag_part (imag_part),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.magnitude (magnitude),
		.angle     (angle)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic polar_t to_polar(input sample_t s);
		longint          are, aim, x, y, z, dx, dy;
		longint unsigned sq, root, bitv;
		polar_t          p;
		are = (s.re < 0) ? -longint'(s.re) : longint'(s.re);
		aim = (s.im < 0) ? -longint'(s.im) : longint'(s.im);
		if (are == 0 && aim == 0) begin
			p.mag = '0;
			p.ang = '0;
			return p;
		end
		sq   = longint'(are * are + aim * aim);
		root = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > sq)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (sq >= root + bitv) begin
				sq   = sq - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		if (sq > root)
			root = root + 1;
		p.mag = (root > 64'hFFFF) ? 16'hFFFF : root[MAG_W-1:0];
		if (s.re >= 0) begin
			x = are <<< GUARD;
			y = aim <<< GUARD;
			z = 0;
		end else begin
			x = aim <<< GUARD;
			y = are <<< GUARD;
			z = 64'sd536870912;
		end
		for (int i = 0; i < ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + atan_tbl[i % 32];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - atan_tbl[i % 32];
			end
		end
		if (z < 0)
			z = 0;
		if (z > 64'sd1073741824)
			z = 64'sd1073741824;
		p.ang = ANGLE_W'((z + 64'sd16384) >>> ZFRAC);
		return p;
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		int      kind;
		kind = $urandom_range(9);
		s.re = SW'($urandom);
		s.im = SW'($urandom);
		if (kind >= 6 && kind <= 7) begin
			s.re = SW'($urandom_range(32) - 16);
			s.im = SW'($urandom_range(32) - 16);
		end else if (kind == 8) begin
			if ($urandom_range(1))
				s.re = '0;
			else
				s.im = '0;
		end else if (kind == 9) begin
			s.re = $urandom_range(1) ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
			s.im = $urandom_range(1) ? SW'($urandom_range(3) - 1) : s.im;
		end
		return s;
	endfunction

	task automatic add(input int re, input int im);
		sample_t s;
		s.re = SW'(re);
		s.im = SW'(im);
		pend_q.push_back(s);
		n_directed++;
	endtask

	task automatic run_phase(input int idle, input int stall, input int count);
		send_idle_pct = idle;
		stall_pct     = stall;
		repeat (count)
			pend_q.push_back(rand_sample());
		while (pend_q.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		sample_t cur;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur = pend_q.pop_front();
				in_valid  <= 1'b1;
				real_part <= cur.re;
				imag_part <= cur.im;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver; one long hold-off when requested
	always @(negedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// request capture and result checking
	always @(posedge clk) begin
		sample_t got;
		polar_t  want;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			got.re = real_part;
			got.im = imag_part;
			polar_q.push_back(to_polar(got));
			n_in++;
		end
		if (arst_n && in_stall)
			n_full++;
		if (arst_n && out_valid && !out_stall) begin
			n_out++;
			if (polar_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("ERROR: result mag=%0d ang=%0d with none expected",
						magnitude, angle);
			end else begin
				want = polar_q.pop_front();
				if (magnitude !== want.mag || angle !== want.ang) begin
					n_err++;
					if (n_err <= 10)
						$display("ERROR: result %0d: mag exp %0d got %0d, ang exp %0d got %0d",
							n_out, want.mag, magnitude, want.ang, angle);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners, axes, quadrants, near-pi and the zero sample
		add(0, 0);
		add(32767, 0);
		add(-32768, 0);
		add(0, 32767);
		add(0, -32768);
		add(32767, 32767);
		add(-32768, -32768);
		add(-32768, 32767);
		add(32767, -32768);
		add(1, 0);
		add(-1, 0);
		add(0, 1);
		add(0, -1);
		add(1, 1);
		add(-1, -1);
		add(-1, 1);
		add(3, 4);
		add(-3, -4);
		add(100, -1);
		add(-32768, 1);
		add(-32768, -1);
		add(-21846, 21845);
		run_phase(0, 0, 0);

		run_phase(0, 0, 300);
		run_phase(67, 0, 300);
		run_phase(0, 67, 300);
		run_phase(7, 7, 200);
		hold_req = 1'b1;
		run_phase(0, 0, 150);

		while (polar_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Checked %0d of %0d samples (%0d directed) over five idle/stall mixes;",
			n_out, n_in, n_directed);
		$display("input held off %0d cycles in total, including one long output hold",
			n_full);
		if (n_err == 0 && polar_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", n_err, polar_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
